/* rtl/sosp_pkg.sv */
package sosp_pkg;

	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_PIPE = 8'h7C;
	localparam logic [7:0] CH_SP   = 8'h20;

	localparam logic [1:0] QM_NONE = 2'd0;
	localparam logic [1:0] QM_DQ   = 2'd1;
	localparam logic [1:0] QM_SQ   = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	// output slots of one command, in emission order
	localparam int NSLOT = 10;
	localparam logic [3:0] SLOT_A_SP0  = 4'd0;
	localparam logic [3:0] SLOT_A_OP0  = 4'd1;
	localparam logic [3:0] SLOT_A_OP1  = 4'd2;
	localparam logic [3:0] SLOT_A_SP1  = 4'd3;
	localparam logic [3:0] SLOT_CHAR   = 4'd4;
	localparam logic [3:0] SLOT_B_SP0  = 4'd5;
	localparam logic [3:0] SLOT_B_OP0  = 4'd6;
	localparam logic [3:0] SLOT_B_OP1  = 4'd7;
	localparam logic [3:0] SLOT_B_SP1  = 4'd8;
	localparam logic [3:0] SLOT_MARK   = 4'd9;

	typedef struct packed {
		logic [7:0] a_op;    // operator flushed ahead of the byte
		logic [1:0] a_cnt;
		logic       c_put;   // byte copied through
		logic [7:0] c_char;
		logic [7:0] b_op;    // operator flushed at line end
		logic [1:0] b_cnt;
		logic       eol;
		logic       err;
	} cmd_t;

	function automatic logic [NSLOT-1:0] slot_mask(cmd_t c);
		logic [NSLOT-1:0] m;
		logic mark;
		m = '0;
		m[SLOT_A_SP0] = (c.a_cnt != 2'd0);
		m[SLOT_A_OP0] = (c.a_cnt != 2'd0);
		m[SLOT_A_OP1] = (c.a_cnt == 2'd2);
		m[SLOT_A_SP1] = (c.a_cnt != 2'd0);
		m[SLOT_CHAR]  = c.c_put;
		m[SLOT_B_SP0] = (c.b_cnt != 2'd0);
		m[SLOT_B_OP0] = (c.b_cnt != 2'd0);
		m[SLOT_B_OP1] = (c.b_cnt == 2'd2);
		m[SLOT_B_SP1] = (c.b_cnt != 2'd0);
		mark = c.eol && (c.err || (m[SLOT_B_SP1:SLOT_A_SP0] == '0));
		m[SLOT_MARK]  = mark;
		return m;
	endfunction

endpackage

/* rtl/sosp_if.sv */
interface sosp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       has_char;
	logic       end_of_line;

	modport source (output valid, in_char, has_char, end_of_line, input ready);
	modport sink   (input valid, in_char, has_char, end_of_line, output ready);
endinterface

interface sosp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       syntax_error;
	logic       last;

	modport source (output valid, out_char, char_valid, syntax_error, last, input ready);
	modport sink   (input valid, out_char, char_valid, syntax_error, last, output ready);
endinterface

/* rtl/sosp_front.sv */
module sosp_front (
	input  logic             clk,
	input  logic             arst_n,
	sosp_in_if.sink          cmd_line,
	input  logic             full,
	output logic             push,
	output sosp_pkg::cmd_t   push_data
);

	logic [1:0] qm_q, qm_d;
	logic [7:0] po_q, po_d;
	logic [1:0] pc_q, pc_d;
	logic       failed_q, failed_d;
	logic       accept;
	logic       is_op;
	sosp_pkg::cmd_t cmd;

	assign cmd_line.ready = !full;
	assign accept = cmd_line.valid && cmd_line.ready;
	assign is_op = (cmd_line.in_char == sosp_pkg::CH_GT) ||
		(cmd_line.in_char == sosp_pkg::CH_LT) ||
		(cmd_line.in_char == sosp_pkg::CH_PIPE);

	always_comb begin
		qm_d     = qm_q;
		po_d     = po_q;
		pc_d     = pc_q;
		failed_d = failed_q;
		cmd      = '0;
		cmd.c_char = cmd_line.in_char;
		if (cmd_line.has_char && !failed_q) begin
			if (qm_q != sosp_pkg::QM_NONE) begin
				cmd.c_put = 1'b1;
				if ((qm_q == sosp_pkg::QM_DQ && cmd_line.in_char == sosp_pkg::CH_DQ) ||
					(qm_q == sosp_pkg::QM_SQ && cmd_line.in_char == sosp_pkg::CH_SQ)) begin
					qm_d = sosp_pkg::QM_NONE;
				end
			end else if (pc_q != 2'd0 && cmd_line.in_char == po_q) begin
				if (po_q == sosp_pkg::CH_PIPE || pc_q == 2'd2) begin
					failed_d = 1'b1;
					po_d     = '0;
					pc_d     = '0;
				end else begin
					pc_d = 2'd2;
				end
			end else begin
				cmd.a_op  = po_q;
				cmd.a_cnt = pc_q;
				po_d      = '0;
				pc_d      = '0;
				if (is_op) begin
					po_d = cmd_line.in_char;
					pc_d = 2'd1;
				end else begin
					cmd.c_put = 1'b1;
					if (cmd_line.in_char == sosp_pkg::CH_DQ) begin
						qm_d = sosp_pkg::QM_DQ;
					end else if (cmd_line.in_char == sosp_pkg::CH_SQ) begin
						qm_d = sosp_pkg::QM_SQ;
					end
				end
			end
		end
		if (cmd_line.end_of_line) begin
			cmd.eol = 1'b1;
			if (failed_d) begin
				cmd.err   = 1'b1;
				cmd.a_cnt = '0;
				cmd.c_put = 1'b0;
			end else begin
				cmd.b_op  = po_d;
				cmd.b_cnt = pc_d;
			end
			qm_d     = sosp_pkg::QM_NONE;
			po_d     = '0;
			pc_d     = '0;
			failed_d = 1'b0;
		end
	end

	assign push      = accept && (sosp_pkg::slot_mask(cmd) != '0);
	assign push_data = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qm_q     <= sosp_pkg::QM_NONE;
			po_q     <= '0;
			pc_q     <= '0;
			failed_q <= 1'b0;
		end else if (accept) begin
			qm_q     <= qm_d;
			po_q     <= po_d;
			pc_q     <= pc_d;
			failed_q <= failed_d;
		end
	end

endmodule

/* rtl/sosp_fifo.sv */
module sosp_fifo #(
	parameter int DEPTH = sosp_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sosp_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output sosp_pkg::cmd_t head,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sosp_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/sosp_back.sv */
module sosp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sosp_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	sosp_out_if.source     spaced_line
);

	localparam int N = sosp_pkg::NSLOT;

	logic           busy_q;
	logic [N-1:0]   mask_q;
	sosp_pkg::cmd_t cmd_q;
	logic           ov_q;
	logic [7:0]     och_q;
	logic           ocv_q, oerr_q, olast_q;

	logic           adv, emit, done;
	logic [3:0]     idx;
	logic [N-1:0]   rest;
	logic [7:0]     sch;
	logic           scv;

	assign adv  = !ov_q || spaced_line.ready;
	assign emit = busy_q && adv;

	// lowest pending slot
	always_comb begin
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = 4'(i);
			end
		end
	end

	assign rest = mask_q & ~(N'(1) << idx);
	assign done = emit && (rest == '0);
	assign pop  = !empty && (!busy_q || done);

	always_comb begin
		sch = sosp_pkg::CH_SP;
		scv = 1'b1;
		case (idx)
			sosp_pkg::SLOT_A_OP0, sosp_pkg::SLOT_A_OP1: sch = cmd_q.a_op;
			sosp_pkg::SLOT_B_OP0, sosp_pkg::SLOT_B_OP1: sch = cmd_q.b_op;
			sosp_pkg::SLOT_CHAR: sch = cmd_q.c_char;
			sosp_pkg::SLOT_MARK: begin
				sch = '0;
				scv = 1'b0;
			end
			default: sch = sosp_pkg::CH_SP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				mask_q <= sosp_pkg::slot_mask(head);
			end else if (done) begin
				busy_q <= 1'b0;
				mask_q <= '0;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (adv) begin
				ov_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (emit) begin
			och_q   <= sch;
			ocv_q   <= scv;
			oerr_q  <= scv ? 1'b0 : cmd_q.err;
			olast_q <= cmd_q.eol && (rest == '0);
		end
	end

	assign spaced_line.valid        = ov_q;
	assign spaced_line.out_char     = och_q;
	assign spaced_line.char_valid   = ocv_q;
	assign spaced_line.syntax_error = oerr_q;
	assign spaced_line.last         = olast_q;

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (mask_q != '0))
		else $error("busy with no slot left");
	a_err_is_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oerr_q) |-> (olast_q && !ocv_q))
		else $error("error flag off a bare end marker");
	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !ocv_q) |-> olast_q)
		else $error("bare marker not last");
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q || done))
		else $error("command loaded over live one");

endmodule

/* rtl/shell_operator_spacer.sv */
// channel      dir   payload                                       transfer
// cmd_line     in    in_char[8] has_char end_of_line               valid & ready
// spaced_line  out   out_char[8] char_valid syntax_error last      valid & ready
//
// the front takes one item per cycle while the command queue has room
// the back sends one result per cycle while the receiver takes them; an item
// gives from 1 to 7 results; items giving no result (a held operator) are
// never queued and so never reach the back
// arst_n clears quote mode, the held operator, the error flag, the queue and the back
// a result waiting in the output register stalls the back; the queue lets the front run on
module shell_operator_spacer #(
	parameter int QUEUE_DEPTH = sosp_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sosp_in_if.sink    cmd_line,
	sosp_out_if.source spaced_line
);

	// front to queue
	logic           push;
	sosp_pkg::cmd_t push_data;
	logic           full;

	// queue to back
	logic           pop;
	sosp_pkg::cmd_t head;
	logic           empty;

	// front: tracks quotes and held operators, turns each item into a command, queued only if it gives output
	sosp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_line  (cmd_line),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// short command queue so either side can stall alone
	sosp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// back: walks the slots of each command, at most one output byte per transfer
	sosp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.spaced_line (spaced_line)
	);

endmodule

/* dv/spacing_checker.sv */
module spacing_checker (
	input  logic clk,
	input  logic arst_n,
	sosp_in_if   cmd_line,
	sosp_out_if  spaced_line,
	output int   fail_count,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       syntax_error;
		logic       last;
	} spaced_t;

	spaced_t    spaced_due[$];
	logic [1:0] quote_st = sosp_pkg::QM_NONE;
	logic [7:0] held_op  = '0;
	logic [1:0] held_cnt = '0;
	logic       line_bad = 1'b0;
	int         mismatches = 0;

	task automatic put_char(input logic [7:0] ch);
		spaced_due.push_back('{out_char: ch, char_valid: 1'b1, syntax_error: 1'b0, last: 1'b0});
	endtask

	// write out a held operator with its surrounding spaces
	task automatic flush_held();
		if (held_cnt != 2'd0) begin
			put_char(sosp_pkg::CH_SP);
			put_char(held_op);
			if (held_cnt == 2'd2)
				put_char(held_op);
			put_char(sosp_pkg::CH_SP);
		end
		held_op  = '0;
		held_cnt = '0;
	endtask

	task automatic take_byte(input logic [7:0] ch);
		if (quote_st != sosp_pkg::QM_NONE) begin
			put_char(ch);
			if ((quote_st == sosp_pkg::QM_DQ && ch == sosp_pkg::CH_DQ) ||
				(quote_st == sosp_pkg::QM_SQ && ch == sosp_pkg::CH_SQ))
				quote_st = sosp_pkg::QM_NONE;
		end else if (held_cnt != 2'd0 && ch == held_op) begin
			// doubled pipe or a third like operator fails the line
			if (held_op == sosp_pkg::CH_PIPE || held_cnt == 2'd2) begin
				line_bad = 1'b1;
				held_op  = '0;
				held_cnt = '0;
			end else begin
				held_cnt = 2'd2;
			end
		end else begin
			flush_held();
			if (ch == sosp_pkg::CH_GT || ch == sosp_pkg::CH_LT || ch == sosp_pkg::CH_PIPE) begin
				held_op  = ch;
				held_cnt = 2'd1;
			end else begin
				if (ch == sosp_pkg::CH_DQ)
					quote_st = sosp_pkg::QM_DQ;
				else if (ch == sosp_pkg::CH_SQ)
					quote_st = sosp_pkg::QM_SQ;
				put_char(ch);
			end
		end
	endtask

	task automatic space_item(input logic [7:0] ch, input logic has, input logic eol);
		int      base;
		spaced_t tail;
		base = spaced_due.size();
		if (has && !line_bad)
			take_byte(ch);
		if (eol) begin
			if (line_bad) begin
				spaced_due.push_back('{out_char: 8'h00, char_valid: 1'b0,
					syntax_error: 1'b1, last: 1'b1});
			end else begin
				flush_held();
				if (spaced_due.size() == base) begin
					spaced_due.push_back('{out_char: 8'h00, char_valid: 1'b0,
						syntax_error: 1'b0, last: 1'b1});
				end else begin
					tail = spaced_due.pop_back();
					tail.last = 1'b1;
					spaced_due.push_back(tail);
				end
			end
			quote_st = sosp_pkg::QM_NONE;
			held_op  = '0;
			held_cnt = '0;
			line_bad = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		spaced_t got;
		spaced_t want;
		if (!arst_n) begin
			spaced_due.delete();
			quote_st = sosp_pkg::QM_NONE;
			held_op  = '0;
			held_cnt = '0;
			line_bad = 1'b0;
		end else begin
			if (cmd_line.valid && cmd_line.ready)
				space_item(cmd_line.in_char, cmd_line.has_char, cmd_line.end_of_line);
			if (spaced_line.valid && spaced_line.ready) begin
				got = '{out_char: spaced_line.out_char, char_valid: spaced_line.char_valid,
					syntax_error: spaced_line.syntax_error, last: spaced_line.last};
				if (spaced_due.size() == 0) begin
					$display("%0t: unexpected transfer: char %h valid %b err %b last %b",
						$time, got.out_char, got.char_valid, got.syntax_error, got.last);
					mismatches++;
				end else begin
					want = spaced_due.pop_front();
					if (got !== want) begin
						$display(
							"%0t: expected %h cv %b err %b last %b, got %h cv %b err %b last %b",
							$time, want.out_char, want.char_valid, want.syntax_error,
							want.last, got.out_char, got.char_valid, got.syntax_error,
							got.last);
						mismatches++;
					end
				end
			end
		end
		fail_count  <= mismatches;
		outstanding <= spaced_due.size();
	end

endmodule

/* dv/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// generous: every item at seven results, each one stalled on both sides
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          RANDOM_ITEMS = 225;
	localparam int          DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        calm;
	int          fail_count;
	int          outstanding;
	int unsigned cycle_count;

	sosp_in_if  cmd_line_bus ();
	sosp_out_if spaced_line_bus ();

	shell_operator_spacer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_line    (cmd_line_bus),
		.spaced_line (spaced_line_bus)
	);

	// watches both channels, predicts the spaced line and counts mismatches
	spacing_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_line    (cmd_line_bus),
		.spaced_line (spaced_line_bus),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: holds off now and then, never while calm
	initial begin
		spaced_line_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			spaced_line_bus.ready <= calm || ($urandom_range(0, 99) >= 13);
		end
	end

	// one transfer on the command line, with a random gap in front of it
	task automatic send_item(input logic [7:0] ch, input logic has, input logic eol);
		while (!calm && $urandom_range(0, 99) < 13) begin
			cmd_line_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_line_bus.valid       <= 1'b1;
		cmd_line_bus.in_char     <= ch;
		cmd_line_bus.has_char    <= has;
		cmd_line_bus.end_of_line <= eol;
		do
			@(posedge clk);
		while (!cmd_line_bus.ready);
	endtask

	// a whole line, the line end riding on its final byte
	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, i == s.len() - 1);
	endtask

	// weighted towards operators and quotes so that the holding logic gets work
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return sosp_pkg::CH_GT;
		else if (r < 22)
			return sosp_pkg::CH_LT;
		else if (r < 32)
			return sosp_pkg::CH_PIPE;
		else if (r < 38)
			return sosp_pkg::CH_DQ;
		else if (r < 44)
			return sosp_pkg::CH_SQ;
		else if (r < 52)
			return sosp_pkg::CH_SP;
		else if (r < 80)
			return 8'h61 + 8'($urandom_range(0, 25));
		else
			return 8'($urandom);
	endfunction

	initial begin
		int sent;
		int len;
		// every input known from time zero
		arst_n                   = 1'b0;
		calm                     = 1'b0;
		cmd_line_bus.valid       = 1'b0;
		cmd_line_bus.in_char     = '0;
		cmd_line_bus.has_char    = 1'b0;
		cmd_line_bus.end_of_line = 1'b0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_item(8'h00, 1'b0, 1'b1);         // empty line gives a bare end marker
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);         // no byte, no line end: nothing at all
		send_item(8'h00, 1'b1, 1'b0);         // zero byte is copied like any other
		send_item(8'hFF, 1'b1, 1'b1);
		send_line("a>b");
		send_line(">><");                     // flush of a doubled operator, then one held at the end
		send_line("||x");                     // doubled pipe fails the line, rest swallowed
		send_line(">>>");                     // three like operators
		send_item(8'h00, 1'b0, 1'b1);         // empty line after the failed one gives a bare end marker
		send_line("'|'");                     // operator inside quotes passes unchanged
		send_line("\"");                      // unclosed quote at line end
		send_line("<<");
		send_line("|");

		// random lines, mostly well formed with a little noise
		while (sent < RANDOM_ITEMS) begin
			len = $urandom_range(0, 10);
			for (int k = 0; k < len; k++) begin
				calm <= (sent >= 90 && sent < 150);
				if ($urandom_range(0, 99) < 5)
					send_item(8'($urandom), 1'b0, 1'b0);
				send_item(pick_char(), 1'b1, 1'b0);
				sent++;
			end
			if ($urandom_range(0, 3) == 0)
				send_item(8'($urandom), 1'b0, 1'b1);
			else
				send_item(pick_char(), 1'b1, 1'b1);
			sent++;
		end
		cmd_line_bus.valid <= 1'b0;
		calm <= 1'b0;

		// drain what is still on its way, then allow for the pipeline
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// hang guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: cycle limit reached", $time);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
